// ===== sv/cpec_pkg.sv =====
// Shared types, widths and constants for the circle pair collision pipeline.
// Used by every module of the block; depends on nothing.
package cpec_pkg;

   localparam int F_W         = 21;
   localparam int R_W         = 16;
   localparam int M_W         = 16;
   localparam int TS_W        = 16;
   localparam int S_W         = 17;
   localparam int NUM_W       = 40;
   localparam int Q_W         = 21;
   localparam int DIV_STAGES  = Q_W + 1;
   localparam int SAT_W       = 23;
   localparam int PROD_W      = 38;
   localparam int D2_W        = 44;
   localparam int REQ_W       = 232;
   localparam int RSP_W       = 216;
   localparam int FRONT_STAGES = 4;
   localparam int BACK_STAGES  = 3;
   localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + BACK_STAGES;
   localparam int RND_HALF    = 32768;

   localparam logic [TS_W-1:0] TS_RESET = 16'd1092;
   localparam logic signed [SAT_W-1:0] SAT_MAX = 23'sd1048575;
   localparam logic signed [SAT_W-1:0] SAT_MIN = -23'sd1048576;

   typedef logic signed [F_W-1:0] fix_type;

   typedef struct packed {
      fix_type          x;
      fix_type          y;
      fix_type          vx;
      fix_type          vy;
      logic [R_W-1:0]   radius;
      logic [M_W-1:0]   mass;
   } circle_type;

   typedef struct packed {
      circle_type first;
      circle_type second;
   } pair_type;

   typedef struct packed {
      logic             neg;
      logic [NUM_W-1:0] mag;
      logic [S_W-1:0]   den;
   } div_in_type;

   typedef struct packed {
      logic           neg;
      logic [Q_W-1:0] quo;
   } div_out_type;

   typedef struct packed {
      logic    hit;
      logic    mzero;
      fix_type x1;
      fix_type y1;
      fix_type vx1;
      fix_type vy1;
      fix_type x2;
      fix_type y2;
      fix_type vx2;
      fix_type vy2;
   } side_type;

   typedef struct packed {
      logic    collided;
      fix_type nx1;
      fix_type ny1;
      fix_type nvx1;
      fix_type nvy1;
      fix_type nx2;
      fix_type ny2;
      fix_type nvx2;
      fix_type nvy2;
      fix_type cx;
      fix_type cy;
   } result_type;

   function automatic fix_type sat(input logic signed [SAT_W-1:0] v);
      fix_type r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[F_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[F_W-1:0];
      end else begin
         r = v[F_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [SAT_W-1:0] signed_quo(input div_out_type d);
      logic signed [SAT_W-1:0] q;
      q = $signed({2'b00, d.quo});
      return d.neg ? -q : q;
   endfunction

endpackage

// ===== sv/cpec_front.sv =====
// Front stages: differences, products, sums and divider operand setup.
// Depends on cpec_pkg.
module cpec_front (
   input  logic                         clock,
   input  logic [3:0]                   adv,
   input  cpec_pkg::pair_type           din,
   output cpec_pkg::div_in_type [5:0]   div_dat,
   output cpec_pkg::side_type           side
);

   // stage 1
   cpec_pkg::pair_type                  p1_ff;
   logic signed [cpec_pkg::F_W:0]       dx1_ff, dx1_in, dy1_ff, dy1_in;
   logic [cpec_pkg::S_W-1:0]            rs1_ff, rs1_in, ms1_ff, ms1_in;
   logic signed [cpec_pkg::S_W-1:0]     md1_ff, md1_in;

   always_comb begin
      dx1_in = {din.first.x[cpec_pkg::F_W-1], din.first.x}
             - {din.second.x[cpec_pkg::F_W-1], din.second.x};
      dy1_in = {din.first.y[cpec_pkg::F_W-1], din.first.y}
             - {din.second.y[cpec_pkg::F_W-1], din.second.y};
      rs1_in = {1'b0, din.first.radius} + {1'b0, din.second.radius};
      ms1_in = {1'b0, din.first.mass} + {1'b0, din.second.mass};
      md1_in = $signed({1'b0, din.first.mass}) - $signed({1'b0, din.second.mass});
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         p1_ff  <= din;
         dx1_ff <= dx1_in;
         dy1_ff <= dy1_in;
         rs1_ff <= rs1_in;
         ms1_ff <= ms1_in;
         md1_ff <= md1_in;
      end
   end

   // stage 2: all products
   cpec_pkg::pair_type                  p2_ff;
   logic signed [cpec_pkg::D2_W-1:0]    dxx2_ff, dxx2_in, dyy2_ff, dyy2_in;
   logic [2*cpec_pkg::S_W-1:0]          rad2_ff, rad2_in;
   logic signed [cpec_pkg::PROD_W-1:0]  pa2_ff [4];
   logic signed [cpec_pkg::PROD_W-1:0]  pa2_in [4];
   logic signed [cpec_pkg::PROD_W-1:0]  pb2_ff [4];
   logic signed [cpec_pkg::PROD_W-1:0]  pb2_in [4];
   logic signed [cpec_pkg::PROD_W-1:0]  pc2_ff [4];
   logic signed [cpec_pkg::PROD_W-1:0]  pc2_in [4];
   logic [cpec_pkg::S_W-1:0]            rs2_ff, ms2_ff;
   logic signed [cpec_pkg::S_W-1:0]     m1s, m2s, r1s, r2s;

   always_comb begin
      m1s = $signed({1'b0, p1_ff.first.mass});
      m2s = $signed({1'b0, p1_ff.second.mass});
      r1s = $signed({1'b0, p1_ff.first.radius});
      r2s = $signed({1'b0, p1_ff.second.radius});
      dxx2_in = dx1_ff * dx1_ff;
      dyy2_in = dy1_ff * dy1_ff;
      rad2_in = rs1_ff * rs1_ff;
      pa2_in[0] = p1_ff.first.vx * md1_ff;
      pb2_in[0] = p1_ff.second.vx * m2s;
      pa2_in[1] = p1_ff.first.vy * md1_ff;
      pb2_in[1] = p1_ff.second.vy * m2s;
      pa2_in[2] = p1_ff.second.vx * md1_ff;
      pb2_in[2] = p1_ff.first.vx * m1s;
      pa2_in[3] = p1_ff.second.vy * md1_ff;
      pb2_in[3] = p1_ff.first.vy * m1s;
      pc2_in[0] = p1_ff.first.x * r2s;
      pc2_in[1] = p1_ff.second.x * r1s;
      pc2_in[2] = p1_ff.first.y * r2s;
      pc2_in[3] = p1_ff.second.y * r1s;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         p2_ff   <= p1_ff;
         dxx2_ff <= dxx2_in;
         dyy2_ff <= dyy2_in;
         rad2_ff <= rad2_in;
         pa2_ff  <= pa2_in;
         pb2_ff  <= pb2_in;
         pc2_ff  <= pc2_in;
         rs2_ff  <= rs1_ff;
         ms2_ff  <= ms1_ff;
      end
   end

   // stage 3: sums
   cpec_pkg::pair_type                  p3_ff;
   logic [cpec_pkg::D2_W:0]             dist3_ff, dist3_in;
   logic [2*cpec_pkg::S_W-1:0]          rad3_ff;
   logic signed [cpec_pkg::NUM_W-1:0]   num3_ff [6];
   logic signed [cpec_pkg::NUM_W-1:0]   num3_in [6];
   logic [cpec_pkg::S_W-1:0]            rs3_ff, ms3_ff;

   always_comb begin
      dist3_in = {1'b0, dxx2_ff[cpec_pkg::D2_W-1:0]} + {1'b0, dyy2_ff[cpec_pkg::D2_W-1:0]};
      num3_in[0] = cpec_pkg::NUM_W'(pa2_ff[0]) + (cpec_pkg::NUM_W'(pb2_ff[0]) <<< 1);
      num3_in[1] = cpec_pkg::NUM_W'(pa2_ff[1]) + (cpec_pkg::NUM_W'(pb2_ff[1]) <<< 1);
      num3_in[2] = (cpec_pkg::NUM_W'(pb2_ff[2]) <<< 1) - cpec_pkg::NUM_W'(pa2_ff[2]);
      num3_in[3] = (cpec_pkg::NUM_W'(pb2_ff[3]) <<< 1) - cpec_pkg::NUM_W'(pa2_ff[3]);
      num3_in[4] = cpec_pkg::NUM_W'(pc2_ff[0]) + cpec_pkg::NUM_W'(pc2_ff[1]);
      num3_in[5] = cpec_pkg::NUM_W'(pc2_ff[2]) + cpec_pkg::NUM_W'(pc2_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         p3_ff    <= p2_ff;
         dist3_ff <= dist3_in;
         rad3_ff  <= rad2_ff;
         num3_ff  <= num3_in;
         rs3_ff   <= rs2_ff;
         ms3_ff   <= ms2_ff;
      end
   end

   // stage 4: hit test, magnitudes with half divisor for rounding
   cpec_pkg::div_in_type [5:0]          div4_ff, div4_in;
   cpec_pkg::side_type                  side4_ff, side4_in;
   logic [cpec_pkg::NUM_W-1:0]          absn [6];
   logic [cpec_pkg::S_W-1:0]            den [6];

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         den[i] = (i < 4) ? ms3_ff : rs3_ff;
         absn[i] = num3_ff[i][cpec_pkg::NUM_W-1] ? cpec_pkg::NUM_W'(-num3_ff[i])
                                                  : cpec_pkg::NUM_W'(num3_ff[i]);
         div4_in[i].neg = num3_ff[i][cpec_pkg::NUM_W-1];
         div4_in[i].den = den[i];
         div4_in[i].mag = absn[i] + cpec_pkg::NUM_W'(den[i][cpec_pkg::S_W-1:1]);
      end
      side4_in.hit   = dist3_ff < {{(cpec_pkg::D2_W + 1 - 2*cpec_pkg::S_W){1'b0}}, rad3_ff};
      side4_in.mzero = (ms3_ff == '0);
      side4_in.x1    = p3_ff.first.x;
      side4_in.y1    = p3_ff.first.y;
      side4_in.vx1   = p3_ff.first.vx;
      side4_in.vy1   = p3_ff.first.vy;
      side4_in.x2    = p3_ff.second.x;
      side4_in.y2    = p3_ff.second.y;
      side4_in.vx2   = p3_ff.second.vx;
      side4_in.vy2   = p3_ff.second.vy;
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         div4_ff  <= div4_in;
         side4_ff <= side4_in;
      end
   end

   assign div_dat = div4_ff;
   assign side    = side4_ff;

endmodule

// ===== sv/cpec_div.sv =====
// Pipelined restoring divider: range check stage, then one quotient bit per stage.
// Depends on cpec_pkg.
module cpec_div (
   input  logic                                 clock,
   input  logic [cpec_pkg::DIV_STAGES-1:0]      adv,
   input  cpec_pkg::div_in_type                 din,
   output cpec_pkg::div_out_type                dout
);

   localparam int QW = cpec_pkg::Q_W;
   localparam int NW = cpec_pkg::NUM_W;

   logic [NW-1:0]             rem_ff [QW+1];
   logic [cpec_pkg::S_W-1:0]  den_ff [QW+1];
   logic [QW-1:0]             quo_ff [QW+1];
   logic                      neg_ff [QW+1];
   logic                      ovf_ff [QW+1];
   logic                      ovf_in;

   // quotient would not fit: saturates downstream anyway
   assign ovf_in = din.mag >= (NW'(din.den) << QW);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         rem_ff[0] <= din.mag;
         den_ff[0] <= din.den;
         quo_ff[0] <= '0;
         neg_ff[0] <= din.neg;
         ovf_ff[0] <= ovf_in;
      end
   end

   for (genvar s = 1; s <= QW; s++) begin : g_step
      localparam int K = QW - s;
      logic [NW-1:0] trial;
      logic          ge;
      logic [NW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      always_comb begin
         trial  = NW'(den_ff[s-1]) << K;
         ge     = rem_ff[s-1] >= trial;
         rem_in = ge ? (rem_ff[s-1] - trial) : rem_ff[s-1];
         quo_in = quo_ff[s-1];
         quo_in[K] = ge;
      end

      always_ff @(posedge clock) begin
         if (adv[s]) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_ff[s-1];
            quo_ff[s] <= quo_in;
            neg_ff[s] <= neg_ff[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
         end
      end
   end

   assign dout.neg = neg_ff[QW];
   assign dout.quo = ovf_ff[QW] ? '1 : quo_ff[QW];

endmodule

// ===== sv/cpec_back.sv =====
// Back stages: velocity selection, position step product, rounding and saturation.
// Depends on cpec_pkg.
module cpec_back (
   input  logic                          clock,
   input  logic [2:0]                    adv,
   input  cpec_pkg::side_type            side,
   input  cpec_pkg::div_out_type [5:0]   quo,
   input  logic [cpec_pkg::TS_W-1:0]     time_step,
   output cpec_pkg::result_type          res
);

   // stage 1: signed quotients, saturate, pick velocities
   cpec_pkg::fix_type nv1_ff [4];
   cpec_pkg::fix_type nv1_in [4];
   cpec_pkg::fix_type pos1_ff [4];
   cpec_pkg::fix_type pos1_in [4];
   cpec_pkg::fix_type con1_ff [2];
   cpec_pkg::fix_type con1_in [2];
   cpec_pkg::fix_type vorig [4];
   logic              hit1_ff;

   always_comb begin
      vorig[0] = side.vx1;
      vorig[1] = side.vy1;
      vorig[2] = side.vx2;
      vorig[3] = side.vy2;
      pos1_in[0] = side.x1;
      pos1_in[1] = side.y1;
      pos1_in[2] = side.x2;
      pos1_in[3] = side.y2;
      for (int i = 0; i < 4; i++) begin
         nv1_in[i] = (!side.hit || side.mzero) ? vorig[i]
                                               : cpec_pkg::sat(cpec_pkg::signed_quo(quo[i]));
      end
      for (int j = 0; j < 2; j++) begin
         con1_in[j] = side.hit ? cpec_pkg::sat(cpec_pkg::signed_quo(quo[4+j])) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         nv1_ff  <= nv1_in;
         pos1_ff <= pos1_in;
         con1_ff <= con1_in;
         hit1_ff <= side.hit;
      end
   end

   // stage 2: velocity times step
   logic signed [cpec_pkg::PROD_W-1:0] pr2_ff [4];
   logic signed [cpec_pkg::PROD_W-1:0] pr2_in [4];
   cpec_pkg::fix_type nv2_ff [4];
   cpec_pkg::fix_type pos2_ff [4];
   cpec_pkg::fix_type con2_ff [2];
   logic              hit2_ff;
   logic signed [cpec_pkg::TS_W:0] ts_s;

   always_comb begin
      ts_s = $signed({1'b0, time_step});
      for (int i = 0; i < 4; i++) begin
         pr2_in[i] = nv1_ff[i] * ts_s;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         pr2_ff  <= pr2_in;
         nv2_ff  <= nv1_ff;
         pos2_ff <= pos1_ff;
         con2_ff <= con1_ff;
         hit2_ff <= hit1_ff;
      end
   end

   // stage 3: round the step to Q.8 (ties away from zero), add, saturate
   cpec_pkg::result_type               res_ff, res_in;
   cpec_pkg::fix_type                  np [4];
   logic signed [cpec_pkg::PROD_W-1:0] prnd [4];
   logic signed [cpec_pkg::SAT_W-1:0]  step [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prnd[i] = pr2_ff[i] + (pr2_ff[i][cpec_pkg::PROD_W-1]
                                ? cpec_pkg::PROD_W'(cpec_pkg::RND_HALF - 1)
                                : cpec_pkg::PROD_W'(cpec_pkg::RND_HALF));
         step[i] = cpec_pkg::SAT_W'(prnd[i] >>> 16);
         np[i] = hit2_ff ? cpec_pkg::sat(cpec_pkg::SAT_W'(pos2_ff[i]) + step[i]) : pos2_ff[i];
      end
      res_in.collided = hit2_ff;
      res_in.nx1  = np[0];
      res_in.ny1  = np[1];
      res_in.nvx1 = nv2_ff[0];
      res_in.nvy1 = nv2_ff[1];
      res_in.nx2  = np[2];
      res_in.ny2  = np[3];
      res_in.nvx2 = nv2_ff[2];
      res_in.nvy2 = nv2_ff[3];
      res_in.cx   = con2_ff[0];
      res_in.cy   = con2_ff[1];
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ===== sv/circle_pair_elastic_collision.sv =====
// Depth: 29 register stages, set by the 22-stage restoring dividers (a range check, then
// one quotient bit per stage, six in parallel). Throughput: one pair per cycle while rsp
// is not blocked; each stage holds only while full and blocked, so bubbles close up.
// Synchronous reset empties the pipeline and loads time_step with 1092. Depends on
// cpec_pkg and all cpec_ modules.
module circle_pair_elastic_collision (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // x1, y1, vx1, vy1, r1, m1, x2, y2, vx2, vy2, r2, m2
   input  logic [cpec_pkg::REQ_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // nx1, ny1, nvx1, nvy1, nx2, ny2, nvx2, nvy2, cx, cy, zero pad
   output logic [cpec_pkg::RSP_W-1:0]    rsp_tdata,
   // collided
   output logic [0:0]                    rsp_tuser,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cpec_pkg::TS_W-1:0]     csr_wdata
);

   localparam int NS   = cpec_pkg::PIPE_STAGES;
   localparam int DS   = cpec_pkg::DIV_STAGES;
   localparam int DIV0 = cpec_pkg::FRONT_STAGES;
   localparam int BK0  = DIV0 + DS;

   logic [cpec_pkg::TS_W-1:0] ts_ff, ts_in;
   logic [NS-1:0]             vld_ff, vld_in, adv;

   assign csr_ready = 1'b1;
   assign ts_in     = csr_valid ? csr_wdata : ts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff <= cpec_pkg::TS_RESET;
      end else begin
         ts_ff <= ts_in;
      end
   end

   // stage handshake
   assign adv[NS-1] = !vld_ff[NS-1] || rsp_tready;
   for (genvar i = 0; i < NS - 1; i++) begin : g_adv
      assign adv[i] = !vld_ff[i] || adv[i+1];
   end

   assign vld_in[0] = adv[0] ? req_tvalid : vld_ff[0];
   for (genvar i = 1; i < NS; i++) begin : g_vld
      assign vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = vld_ff[NS-1];

   cpec_pkg::pair_type pair;

   assign pair.first.x       = req_tdata[20:0];
   assign pair.first.y       = req_tdata[41:21];
   assign pair.first.vx      = req_tdata[62:42];
   assign pair.first.vy      = req_tdata[83:63];
   assign pair.first.radius  = req_tdata[99:84];
   assign pair.first.mass    = req_tdata[115:100];
   assign pair.second.x      = req_tdata[136:116];
   assign pair.second.y      = req_tdata[157:137];
   assign pair.second.vx     = req_tdata[178:158];
   assign pair.second.vy     = req_tdata[199:179];
   assign pair.second.radius = req_tdata[215:200];
   assign pair.second.mass   = req_tdata[231:216];

   cpec_pkg::div_in_type [5:0]  div_dat;
   cpec_pkg::div_out_type [5:0] div_res;
   cpec_pkg::side_type          side_front;
   cpec_pkg::side_type          side_ff [DS];
   cpec_pkg::result_type        res;

   cpec_front u_front (
      .clock   (clock),
      .adv     (adv[DIV0-1:0]),
      .din     (pair),
      .div_dat (div_dat),
      .side    (side_front)
   );

   for (genvar d = 0; d < 6; d++) begin : g_div
      cpec_div u_div (
         .clock (clock),
         .adv   (adv[BK0-1:DIV0]),
         .din   (div_dat[d]),
         .dout  (div_res[d])
      );
   end

   // sideband follows the dividers
   always_ff @(posedge clock) begin
      if (adv[DIV0]) begin
         side_ff[0] <= side_front;
      end
   end
   for (genvar s = 1; s < DS; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (adv[DIV0+s]) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   cpec_back u_back (
      .clock     (clock),
      .adv       (adv[NS-1:BK0]),
      .side      (side_ff[DS-1]),
      .quo       (div_res),
      .time_step (ts_ff),
      .res       (res)
   );

   assign rsp_tdata = {6'b000000, res.cy, res.cx, res.nvy2, res.nvx2, res.ny2, res.nx2,
                       res.nvy1, res.nvx1, res.ny1, res.nx1};
   assign rsp_tuser = res.collided;

   assert property (@(posedge clock) reset |=> (vld_ff == '0))
      else $error("pipeline not empty after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata[209:168] == '0))
      else $error("contact point nonzero without hit");

   assert property (@(posedge clock) disable iff (reset)
      (&vld_ff) && !rsp_tready |-> !req_tready)
      else $error("full pipeline took a word while blocked");

endmodule
